>>> rtl/core/assert_macros.svh
// Assertion macros used by the top level of the cascaded PI controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
  `ASSERT_CLK(label, clk, rstn, !(cond))

`endif

>>> rtl/core/cscpi_pkg.sv
// Package of the cascaded PI controller: constants, command types and helpers.
package cscpi_pkg;

  // Fixed point format
  localparam int FracBits = 16;
  localparam logic signed [31:0] One = 32'sd1 <<< FracBits;

  // Field and datapath widths
  localparam int CodeW     = 12;
  localparam int DataW     = 32;
  localparam int DutyW     = 28;
  localparam int IrefW     = 20;
  localparam int AmpsW     = 21;
  localparam int FiltW     = 21;
  localparam int VoltsW    = 25;
  localparam int RpmW      = 31;
  localparam int ErrIW     = 22;
  localparam int AccW      = 2 * DataW - FracBits + 2;
  localparam int CfgIdxW   = 3;
  localparam int InTdataW  = 40;
  localparam int OutTdataW = 152;

  // Scaling constants in Q32.32, brought down to FracBits fraction bits
  localparam logic [63:0] Q32IGain = 64'd27019092;
  localparam logic [63:0] Q32IOffs = 64'd56107376798;
  localparam logic [63:0] Q32VGain = 64'd432643222;
  localparam logic [63:0] Q32FIn   = 64'd44495861;
  localparam logic [63:0] Q32FFb   = 64'd4206061472;
  localparam logic [63:0] Q32Rpm   = 64'd31997506355;

  localparam logic signed [31:0] KIGain = 32'(Q32IGain >> (32 - FracBits));
  localparam logic signed [31:0] KIOffs = 32'(Q32IOffs >> (32 - FracBits));
  localparam logic signed [31:0] KVGain = 32'(Q32VGain >> (32 - FracBits));
  localparam logic signed [31:0] KFIn   = 32'(Q32FIn >> (32 - FracBits));
  localparam logic signed [31:0] KFFb   = 32'(Q32FFb >> (32 - FracBits));
  localparam logic signed [31:0] KRpm   = 32'(Q32Rpm >> (32 - FracBits));
  localparam logic signed [31:0] KVOffs = 32'sd212 * One;

  // Output limits
  localparam logic signed [31:0] IrefMax = 32'sd5 * One;
  localparam logic signed [31:0] DutyMin = One;
  localparam logic signed [31:0] DutyMax = 32'sd4000 * One;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSpeedTarget  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpeedGainNow = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSpeedGainPrv = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSpeedGainOut = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgCurGainNow   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgCurGainPrv   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCurGainOut   = 3'd6;

  // Operand pair fed to the shared multiplier
  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_AMPS,
    MUL_VOLTS,
    MUL_RPM,
    MUL_F_NOW,
    MUL_F_PREV,
    MUL_F_FB,
    MUL_S_NOW,
    MUL_S_PREV,
    MUL_S_OUT,
    MUL_C_NOW,
    MUL_C_PREV,
    MUL_C_OUT
  } mul_sel_e;

  // Accumulator action on the registered, shifted product
  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_e;

  // Working register written back this cycle
  typedef enum logic [2:0] {
    WR_NONE,
    WR_AMPS,
    WR_VOLTS,
    WR_RPM,
    WR_FILT,
    WR_IREF,
    WR_DUTY
  } wr_sel_e;

  // Command word from the sequencer to the datapath
  typedef struct packed {
    logic     capture;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    wr_sel_e  wr_sel;
  } dp_cmd_t;

  // Reset value of a gain register given in Q16.16, floored and saturated
  function automatic logic signed [31:0] cfg_reset(input logic signed [63:0] v);
    logic signed [63:0] t;
    t = (v <<< FracBits) >>> 16;
    if (t > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (t < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return t[31:0];
  endfunction

endpackage

>>> rtl/core/cascaded_speed_current_pi.sv
// Cascaded speed and current PI controller, top level.
// One beat in per control tick: raw current and voltage ADC codes and an
// encoder count. One beat out: duty, current reference, scaled current,
// filtered current, bus volts and rpm, all Q16.16. A beat is taken in the idle
// state, then the sequencer runs 14 steps before it is idle again and takes the
// next; the pace is set by the single shared 32x32 multiplier, which forms the
// twelve products of a tick one per cycle. The next beat is taken while a
// finished result still waits on the output; a tick then holds in its last
// step until that result is taken. Registers are to be written through the
// plain write port only while no tick is in progress; the block does not enforce it.
`include "assert_macros.svh"

module cascaded_speed_current_pi
  import cscpi_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // [11:0] current_code, [23:12] voltage_code, [35:24] speed_count, rest zero
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [27:0] duty_value, [47:28] current_reference, [68:48] current_amps,
  // [89:69] current_filtered, [114:90] bus_volts, [145:115] speed_rpm, rest zero
  output logic [OutTdataW-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DataW-1:0]     cfg_wdata_i
);

  dp_cmd_t                  cmd;
  logic [DutyW-1:0]         duty_value;
  logic signed [IrefW-1:0]  current_reference;
  logic signed [AmpsW-1:0]  current_amps;
  logic signed [FiltW-1:0]  current_filtered;
  logic signed [VoltsW-1:0] bus_volts;
  logic [RpmW-1:0]          speed_rpm;

  cscpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  cscpi_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .current_code_i      (s_axis_tdata[11:0]),
    .voltage_code_i      (s_axis_tdata[23:12]),
    .speed_count_i       (s_axis_tdata[35:24]),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .duty_value_o        (duty_value),
    .current_reference_o (current_reference),
    .current_amps_o      (current_amps),
    .current_filtered_o  (current_filtered),
    .bus_volts_o         (bus_volts),
    .speed_rpm_o         (speed_rpm)
  );

  // Output beat packing
  assign m_axis_tdata = {6'd0, speed_rpm, bus_volts, current_filtered, current_amps,
                         current_reference, duty_value};

  // Sequencer goes busy once a beat is taken
  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // A result never appears in the cycle right after an acceptance
  `ASSERT_CLK(a_no_instant_result, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
  // Duty lies inside its clamp window
  `ASSERT_NEVER(a_duty_range, clk_i, rst_ni, m_axis_tvalid && ((m_axis_tdata[27:0] < DutyMin[27:0]) || (m_axis_tdata[27:0] > DutyMax[27:0])))
  // Current reference lies inside plus or minus five amps
  `ASSERT_NEVER(a_iref_range, clk_i, rst_ni, m_axis_tvalid && (($signed(m_axis_tdata[47:28]) > IrefMax) || ($signed(m_axis_tdata[47:28]) < -IrefMax)))

endmodule

>>> rtl/core/cscpi_dp.sv
// Datapath of the cascaded PI controller: registers, shared multiplier, accumulator.
module cscpi_dp
  import cscpi_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  input  logic [CodeW-1:0]         current_code_i,
  input  logic [CodeW-1:0]         voltage_code_i,
  input  logic [CodeW-1:0]         speed_count_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [DataW-1:0]         cfg_wdata_i,
  output logic [DutyW-1:0]         duty_value_o,
  output logic signed [IrefW-1:0]  current_reference_o,
  output logic signed [AmpsW-1:0]  current_amps_o,
  output logic signed [FiltW-1:0]  current_filtered_o,
  output logic signed [VoltsW-1:0] bus_volts_o,
  output logic [RpmW-1:0]          speed_rpm_o
);

  localparam logic signed [AccW-1:0] AccIrefHi = AccW'(IrefMax);
  localparam logic signed [AccW-1:0] AccIrefLo = -AccW'(IrefMax);
  localparam logic signed [AccW-1:0] AccDutyHi = AccW'(DutyMax);
  localparam logic signed [AccW-1:0] AccDutyLo = AccW'(DutyMin);
  localparam logic signed [AccW-1:0] AccS32Max = AccW'(32'sh7fffffff);
  localparam logic signed [AccW-1:0] AccS32Min = AccW'(32'sh80000000);
  localparam logic signed [32:0]     S33Max    = 33'sd2147483647;
  localparam logic signed [32:0]     S33Min    = -33'sd2147483648;

  // Configuration registers
  logic signed [DataW-1:0] speed_target_q, sg_now_q, sg_prev_q, sg_out_q;
  logic signed [DataW-1:0] cg_now_q, cg_prev_q, cg_out_q;

  // Captured input beat
  logic [CodeW-1:0] icode_q, vcode_q, count_q;

  // Working registers of one tick
  logic signed [AmpsW-1:0]  amps_q;
  logic signed [VoltsW-1:0] volts_q;
  logic [RpmW-1:0]          rpm_q;
  logic signed [DataW-1:0]  err_s_q;
  logic signed [DataW-1:0]  filt_q;
  logic signed [IrefW-1:0]  iref_q;
  logic signed [ErrIW-1:0]  err_i_q;
  logic signed [63:0]       prod_q;
  logic signed [AccW-1:0]   acc_q;

  // Controller history, kept between ticks
  logic signed [DataW-1:0]  last_se_q;
  logic signed [IrefW-1:0]  last_iref_q;
  logic signed [ErrIW-1:0]  last_ce_q;
  logic [DutyW-1:0]         last_duty_q;
  logic signed [AmpsW-1:0]  last_sample_q;
  logic signed [DataW-1:0]  last_filt_q;

  // Result registers
  logic [DutyW-1:0]         duty_out_q;
  logic signed [IrefW-1:0]  iref_out_q;
  logic signed [AmpsW-1:0]  amps_out_q;
  logic signed [FiltW-1:0]  filt_out_q;
  logic signed [VoltsW-1:0] volts_out_q;
  logic [RpmW-1:0]          rpm_out_q;

  logic signed [DataW-1:0]  op_a, op_b;
  logic signed [63:0]       prod_d;
  logic signed [63:0]       prod_sh;
  logic signed [63:0]       amps_full, volts_full;
  logic signed [32:0]       err_s_full;
  logic signed [DataW-1:0]  err_s_d;
  logic signed [DataW-1:0]  filt_d;
  logic signed [IrefW-1:0]  iref_d;
  logic signed [ErrIW-1:0]  err_i_d;
  logic [DutyW-1:0]         duty_d;
  logic signed [AccW-1:0]   acc_d;

  // Configuration writes; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_target_q <= cfg_reset(64'sd5242880);
      sg_now_q       <= cfg_reset(64'sd17092);
      sg_prev_q      <= cfg_reset(-64'sd16961);
      sg_out_q       <= cfg_reset(64'sd65536);
      cg_now_q       <= cfg_reset(64'sd12514722);
      cg_prev_q      <= cfg_reset(-64'sd12486469);
      cg_out_q       <= cfg_reset(64'sd65536);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSpeedTarget:  speed_target_q <= cfg_wdata_i;
        CfgSpeedGainNow: sg_now_q       <= cfg_wdata_i;
        CfgSpeedGainPrv: sg_prev_q      <= cfg_wdata_i;
        CfgSpeedGainOut: sg_out_q       <= cfg_wdata_i;
        CfgCurGainNow:   cg_now_q       <= cfg_wdata_i;
        CfgCurGainPrv:   cg_prev_q      <= cfg_wdata_i;
        CfgCurGainOut:   cg_out_q       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_AMPS: begin
        op_a = {{(DataW-CodeW){1'b0}}, icode_q};
        op_b = KIGain;
      end
      MUL_VOLTS: begin
        op_a = {{(DataW-CodeW){1'b0}}, vcode_q};
        op_b = KVGain;
      end
      MUL_RPM: begin
        op_a = {{(DataW-CodeW){1'b0}}, count_q};
        op_b = KRpm;
      end
      MUL_F_NOW: begin
        op_a = KFIn;
        op_b = DataW'(amps_q);
      end
      MUL_F_PREV: begin
        op_a = KFIn;
        op_b = DataW'(last_sample_q);
      end
      MUL_F_FB: begin
        op_a = KFFb;
        op_b = last_filt_q;
      end
      MUL_S_NOW: begin
        op_a = err_s_q;
        op_b = sg_now_q;
      end
      MUL_S_PREV: begin
        op_a = last_se_q;
        op_b = sg_prev_q;
      end
      MUL_S_OUT: begin
        op_a = DataW'(last_iref_q);
        op_b = sg_out_q;
      end
      MUL_C_NOW: begin
        op_a = DataW'(err_i_q);
        op_b = cg_now_q;
      end
      MUL_C_PREV: begin
        op_a = DataW'(last_ce_q);
        op_b = cg_prev_q;
      end
      MUL_C_OUT: begin
        op_a = {{(DataW-DutyW){1'b0}}, last_duty_q};
        op_b = cg_out_q;
      end
      default: ;
    endcase
  end

  assign prod_d  = op_a * op_b;
  assign prod_sh = prod_q >>> FracBits;

  // Accumulator over floored products
  always_comb begin
    acc_d = acc_q;
    case (cmd_i.acc_op)
      ACC_LOAD: acc_d = prod_sh[AccW-1:0];
      ACC_ADD:  acc_d = acc_q + prod_sh[AccW-1:0];
      default:  acc_d = acc_q;
    endcase
  end

  // Scaled measurements straight from the raw product
  assign amps_full  = prod_q - 64'(KIOffs);
  assign volts_full = prod_q - 64'(KVOffs);
  assign err_s_full = 33'(speed_target_q) - $signed({2'b00, prod_q[RpmW-1:0]});

  always_comb begin
    if (err_s_full > S33Max) begin
      err_s_d = 32'sh7fffffff;
    end else if (err_s_full < S33Min) begin
      err_s_d = 32'sh80000000;
    end else begin
      err_s_d = err_s_full[DataW-1:0];
    end
  end

  // Filter saturation and PI output clamps on the accumulated sum
  always_comb begin
    if (acc_q > AccS32Max) begin
      filt_d = 32'sh7fffffff;
    end else if (acc_q < AccS32Min) begin
      filt_d = 32'sh80000000;
    end else begin
      filt_d = acc_q[DataW-1:0];
    end
    if (acc_q > AccIrefHi) begin
      iref_d = AccIrefHi[IrefW-1:0];
    end else if (acc_q < AccIrefLo) begin
      iref_d = AccIrefLo[IrefW-1:0];
    end else begin
      iref_d = acc_q[IrefW-1:0];
    end
    if (acc_q > AccDutyHi) begin
      duty_d = AccDutyHi[DutyW-1:0];
    end else if (acc_q < AccDutyLo) begin
      duty_d = AccDutyLo[DutyW-1:0];
    end else begin
      duty_d = acc_q[DutyW-1:0];
    end
  end

  assign err_i_d = ErrIW'(iref_d) - ErrIW'(amps_q);

  // Working registers and result registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= acc_d;
    if (cmd_i.capture) begin
      icode_q <= current_code_i;
      vcode_q <= voltage_code_i;
      count_q <= speed_count_i;
    end
    case (cmd_i.wr_sel)
      WR_AMPS:  amps_q  <= amps_full[AmpsW-1:0];
      WR_VOLTS: volts_q <= volts_full[VoltsW-1:0];
      WR_RPM: begin
        rpm_q   <= prod_q[RpmW-1:0];
        err_s_q <= err_s_d;
      end
      WR_FILT:  filt_q  <= filt_d;
      WR_IREF: begin
        iref_q  <= iref_d;
        err_i_q <= err_i_d;
      end
      WR_DUTY: begin
        duty_out_q  <= duty_d;
        iref_out_q  <= iref_q;
        amps_out_q  <= amps_q;
        filt_out_q  <= filt_q[FiltW-1:0];
        volts_out_q <= volts_q;
        rpm_out_q   <= rpm_q;
      end
      default: ;
    endcase
  end

  // History of the two PI stages and the filter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_se_q     <= '0;
      last_iref_q   <= '0;
      last_ce_q     <= '0;
      last_duty_q   <= '0;
      last_sample_q <= '0;
      last_filt_q   <= '0;
    end else if (cmd_i.wr_sel == WR_DUTY) begin
      last_se_q     <= err_s_q;
      last_iref_q   <= iref_q;
      last_ce_q     <= err_i_q;
      last_duty_q   <= duty_d;
      last_sample_q <= amps_q;
      last_filt_q   <= filt_q;
    end
  end

  assign duty_value_o        = duty_out_q;
  assign current_reference_o = iref_out_q;
  assign current_amps_o      = amps_out_q;
  assign current_filtered_o  = filt_out_q;
  assign bus_volts_o         = volts_out_q;
  assign speed_rpm_o         = rpm_out_q;

endmodule

>>> rtl/core/cscpi_ctrl.sv
// Sequencer of the cascaded PI controller: one multiply per cycle, then result hand-off.
module cscpi_ctrl
  import cscpi_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AMPS,
    ST_VOLTS,
    ST_RPM,
    ST_F_NOW,
    ST_F_PREV,
    ST_F_FB,
    ST_S_NOW,
    ST_S_PREV,
    ST_S_OUT,
    ST_C_PREV,
    ST_C_OUT,
    ST_C_NOW,
    ST_C_ADD,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   slot_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Command decode and next state; each step from ST_AMPS to ST_C_NOW issues one product,
  // and each step after ST_AMPS up to ST_C_ADD retires the one issued in the step before
  always_comb begin
    cmd_o   = '{capture: 1'b0, mul_sel: MUL_NONE, acc_op: ACC_HOLD, wr_sel: WR_NONE};
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_AMPS;
        end
      end
      ST_AMPS: begin
        cmd_o.mul_sel = MUL_AMPS;
        state_d       = ST_VOLTS;
      end
      ST_VOLTS: begin
        cmd_o.mul_sel = MUL_VOLTS;
        cmd_o.wr_sel  = WR_AMPS;
        state_d       = ST_RPM;
      end
      ST_RPM: begin
        cmd_o.mul_sel = MUL_RPM;
        cmd_o.wr_sel  = WR_VOLTS;
        state_d       = ST_F_NOW;
      end
      ST_F_NOW: begin
        cmd_o.mul_sel = MUL_F_NOW;
        cmd_o.wr_sel  = WR_RPM;
        state_d       = ST_F_PREV;
      end
      ST_F_PREV: begin
        cmd_o.mul_sel = MUL_F_PREV;
        cmd_o.acc_op  = ACC_LOAD;
        state_d       = ST_F_FB;
      end
      ST_F_FB: begin
        cmd_o.mul_sel = MUL_F_FB;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_S_NOW;
      end
      ST_S_NOW: begin
        cmd_o.mul_sel = MUL_S_NOW;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_S_PREV;
      end
      ST_S_PREV: begin
        cmd_o.mul_sel = MUL_S_PREV;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.wr_sel  = WR_FILT;
        state_d       = ST_S_OUT;
      end
      ST_S_OUT: begin
        cmd_o.mul_sel = MUL_S_OUT;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_C_PREV;
      end
      ST_C_PREV: begin
        cmd_o.mul_sel = MUL_C_PREV;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_C_OUT;
      end
      ST_C_OUT: begin
        cmd_o.mul_sel = MUL_C_OUT;
        cmd_o.acc_op  = ACC_LOAD;
        cmd_o.wr_sel  = WR_IREF;
        state_d       = ST_C_NOW;
      end
      ST_C_NOW: begin
        cmd_o.mul_sel = MUL_C_NOW;
        cmd_o.acc_op  = ACC_ADD;
        state_d       = ST_C_ADD;
      end
      ST_C_ADD: begin
        cmd_o.acc_op = ACC_ADD;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here until the result register is free
        if (slot_free) begin
          cmd_o.wr_sel = WR_DUTY;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_FINISH && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> sim/testbench.sv
// Self-checking testbench for the cascaded speed and current PI controller.
`timescale 1ns / 1ps

module testbench;
  import cscpi_pkg::*;

  // Fixed point scaling, Q16.16
  localparam int     QShift     = 16;
  localparam longint QOne       = longint'(1) << QShift;
  localparam longint AmpsGain   = longint'(64'd27019092 >> QShift);
  localparam longint AmpsOffs   = longint'(64'd56107376798 >> QShift);
  localparam longint VoltsGain  = longint'(64'd432643222 >> QShift);
  localparam longint VoltsOffs  = 212 * QOne;
  localparam longint FiltIn     = longint'(64'd44495861 >> QShift);
  localparam longint FiltFb     = longint'(64'd4206061472 >> QShift);
  localparam longint RpmGain    = longint'(64'd31997506355 >> QShift);
  localparam longint IrefCap    = 5 * QOne;
  localparam longint DutyLo     = QOne;
  localparam longint DutyHi     = 4000 * QOne;

  // Register index that decodes to nothing
  localparam logic [CfgIdxW-1:0] CfgUnused = 3'd7;

  // Register reset values
  localparam int TargetRst  = 5242880;
  localparam int SNowRst    = 17092;
  localparam int SPrevRst   = -16961;
  localparam int SOutRst    = 65536;
  localparam int CNowRst    = 12514722;
  localparam int CPrevRst   = -12486469;
  localparam int COutRst    = 65536;

  localparam int MaxGap      = 17;
  localparam int DrainCycles = 40;
  localparam int HoldCycles  = 400;
  localparam int CycleLimit  = 800000;
  localparam int PrintLimit  = 60;

  // Result beat layout, lowest field last
  typedef struct packed {
    logic [RpmW-1:0]   speed_rpm;
    logic [VoltsW-1:0] bus_volts;
    logic [FiltW-1:0]  current_filtered;
    logic [AmpsW-1:0]  current_amps;
    logic [IrefW-1:0]  current_reference;
    logic [DutyW-1:0]  duty_value;
  } tick_result_t;

  localparam int ResultW = $bits(tick_result_t);

  typedef struct {
    logic [CfgIdxW-1:0] idx;
    logic [DataW-1:0]   data;
  } reg_write_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic [InTdataW-1:0]  s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [DataW-1:0]     cfg_wdata_i;

  cascaded_speed_current_pi dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Controller mirror: settings and loop history
  int cfg_target, cfg_s_now, cfg_s_prev, cfg_s_out;
  int cfg_c_now, cfg_c_prev, cfg_c_out;
  int prev_speed_err, prev_iref, prev_cur_err, prev_duty, prev_amps, prev_filt;

  tick_result_t expected_ticks[$];
  reg_write_t   pending_writes[$];

  int          mismatches   = 0;
  int          checked_beats = 0;
  int          cycle_count  = 0;
  int unsigned src_max_gap  = MaxGap;
  int unsigned sink_max_gap = MaxGap;
  int unsigned sink_hold    = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Run-away guard
  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int sat32(input longint v);
    if (v > longint'(32'sh7fffffff)) return 32'sh7fffffff;
    if (v < -longint'(32'sh7fffffff) - 1) return 32'sh80000000;
    return int'(v);
  endfunction

  // Q16.16 product, floored
  function automatic longint qmul(input longint a, input longint b);
    return (a * b) >>> QShift;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic reset_model();
    cfg_target = TargetRst;
    cfg_s_now  = SNowRst;
    cfg_s_prev = SPrevRst;
    cfg_s_out  = SOutRst;
    cfg_c_now  = CNowRst;
    cfg_c_prev = CPrevRst;
    cfg_c_out  = COutRst;
    prev_speed_err = 0;
    prev_iref      = 0;
    prev_cur_err   = 0;
    prev_duty      = 0;
    prev_amps      = 0;
    prev_filt      = 0;
  endtask

  // One control tick of the cascade; advances the loop history
  function automatic tick_result_t predict_tick(input logic [CodeW-1:0] cur,
                                                input logic [CodeW-1:0] volt,
                                                input logic [CodeW-1:0] spd);
    longint amps, volts, rpm, err_s, iref, filt, err_i, duty;
    tick_result_t r;
    amps  = longint'(cur) * AmpsGain - AmpsOffs;
    volts = longint'(volt) * VoltsGain - VoltsOffs;
    rpm   = sat32(longint'(spd) * RpmGain);

    // speed stage
    err_s = sat32(longint'(cfg_target) - rpm);
    iref  = qmul(err_s, cfg_s_now) + qmul(prev_speed_err, cfg_s_prev)
          + qmul(prev_iref, cfg_s_out);
    iref  = clip(iref, -IrefCap, IrefCap);

    // current low-pass
    filt = sat32(qmul(FiltIn, amps) + qmul(FiltIn, prev_amps) + qmul(FiltFb, prev_filt));

    // current stage
    err_i = iref - amps;
    duty  = qmul(err_i, cfg_c_now) + qmul(prev_cur_err, cfg_c_prev)
          + qmul(prev_duty, cfg_c_out);
    duty  = clip(duty, DutyLo, DutyHi);

    prev_speed_err = int'(err_s);
    prev_iref      = int'(iref);
    prev_cur_err   = sat32(err_i);
    prev_duty      = int'(duty);
    prev_amps      = sat32(amps);
    prev_filt      = int'(filt);

    r.duty_value        = duty[DutyW-1:0];
    r.current_reference = iref[IrefW-1:0];
    r.current_amps      = amps[AmpsW-1:0];
    r.current_filtered  = filt[FiltW-1:0];
    r.bus_volts         = volts[VoltsW-1:0];
    r.speed_rpm         = rpm[RpmW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    if (mismatches <= PrintLimit) begin
      $display("mismatch on %0s at beat %0d: got 0x%0h, want 0x%0h",
               what, checked_beats, got, want);
    end
  endtask

  // Mirror register writes and accepted input beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSpeedTarget:  cfg_target = cfg_wdata_i;
          CfgSpeedGainNow: cfg_s_now  = cfg_wdata_i;
          CfgSpeedGainPrv: cfg_s_prev = cfg_wdata_i;
          CfgSpeedGainOut: cfg_s_out  = cfg_wdata_i;
          CfgCurGainNow:   cfg_c_now  = cfg_wdata_i;
          CfgCurGainPrv:   cfg_c_prev = cfg_wdata_i;
          CfgCurGainOut:   cfg_c_out  = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_ticks.push_back(predict_tick(s_axis_tdata[11:0], s_axis_tdata[23:12],
                                              s_axis_tdata[35:24]));
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk_i) begin : beat_checker
    tick_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[ResultW-1:0];
      if (expected_ticks.size() == 0) begin
        report_mismatch("unexpected beat", longint'(got.duty_value), 0);
      end else begin
        want = expected_ticks.pop_front();
        if (got.duty_value != want.duty_value)
          report_mismatch("duty_value", got.duty_value, want.duty_value);
        if (got.current_reference != want.current_reference)
          report_mismatch("current_reference", got.current_reference,
                          want.current_reference);
        if (got.current_amps != want.current_amps)
          report_mismatch("current_amps", got.current_amps, want.current_amps);
        if (got.current_filtered != want.current_filtered)
          report_mismatch("current_filtered", got.current_filtered,
                          want.current_filtered);
        if (got.bus_volts != want.bus_volts)
          report_mismatch("bus_volts", got.bus_volts, want.bus_volts);
        if (got.speed_rpm != want.speed_rpm)
          report_mismatch("speed_rpm", got.speed_rpm, want.speed_rpm);
        if (m_axis_tdata[OutTdataW-1:ResultW] != '0)
          report_mismatch("tdata padding", m_axis_tdata[OutTdataW-1:ResultW], 0);
      end
      checked_beats++;
    end
  end

  // Result sink: random stall before each beat, plus long hold-offs on request
  initial begin : result_sink
    int unsigned gap;
    gap = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) gap = $urandom_range(0, sink_max_gap);
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (gap > 0) begin
        gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one input beat after a random gap and wait for it to be taken
  task automatic send_tick(input logic [CodeW-1:0] cur, input logic [CodeW-1:0] volt,
                           input logic [CodeW-1:0] spd);
    int unsigned gap;
    gap = $urandom_range(0, src_max_gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= InTdataW'({spd, volt, cur});
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Stop offering and let every outstanding tick drain
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_reg(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    pending_writes.push_back(w);
  endtask

  task automatic queue_all_regs(input int target, input int s_now, input int s_prev,
                                input int s_out, input int c_now, input int c_prev,
                                input int c_out);
    queue_reg(CfgSpeedTarget, target);
    queue_reg(CfgSpeedGainNow, s_now);
    queue_reg(CfgSpeedGainPrv, s_prev);
    queue_reg(CfgSpeedGainOut, s_out);
    queue_reg(CfgCurGainNow, c_now);
    queue_reg(CfgCurGainPrv, c_prev);
    queue_reg(CfgCurGainOut, c_out);
  endtask

  // Write queued registers back to back; block must be idle
  task automatic apply_writes();
    reg_write_t w;
    wait_idle();
    while (pending_writes.size() != 0) begin
      w = pending_writes.pop_front();
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= w.idx;
      cfg_wdata_i <= w.data;
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic int walk(input int v, input int span);
    int n;
    n = v + int'($urandom_range(0, 2 * span)) - span;
    return (n < 0) ? 0 : ((n > 4095) ? 4095 : n);
  endfunction

  // Reset settings, field extremes and alternating bit patterns
  task automatic test_field_extremes();
    send_tick(12'h000, 12'h000, 12'h000);
    send_tick(12'hfff, 12'hfff, 12'hfff);
    send_tick(12'haaa, 12'h555, 12'haaa);
    send_tick(12'h555, 12'haaa, 12'h555);
    send_tick(12'd2078, 12'd2048, 12'd11);
    send_tick(12'd2078, 12'd2048, 12'd11);
    wait_idle();
  endtask

  // Huge gains drive both clamps; lowest target saturates the speed error
  task automatic test_gain_extremes();
    queue_all_regs(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                   32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    apply_writes();
    send_tick(12'hfff, 12'd2048, 12'hfff);
    send_tick(12'hfff, 12'd2048, 12'hfff);
    queue_all_regs(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h80000000,
                   32'h80000000, 32'h80000000, 32'h80000000);
    apply_writes();
    send_tick(12'h000, 12'd2048, 12'h000);
    send_tick(12'h000, 12'd2048, 12'h000);
    queue_all_regs(32'h80000000, SNowRst, SPrevRst, SOutRst, CNowRst, CPrevRst, COutRst);
    apply_writes();
    send_tick(12'd2078, 12'd2048, 12'hfff);
    send_tick(12'd2078, 12'd2048, 12'hfff);
    queue_all_regs(0, 0, 0, 0, 0, 0, 0);
    apply_writes();
    send_tick(12'd2078, 12'd2048, 12'd11);
    wait_idle();
  endtask

  // A write to an undecoded index leaves all settings alone
  task automatic test_unknown_register();
    queue_all_regs(TargetRst, SNowRst, SPrevRst, SOutRst, CNowRst, CPrevRst, COutRst);
    queue_reg(CfgUnused, $urandom);
    apply_writes();
    send_tick(12'd2100, 12'd3000, 12'd10);
    send_tick(12'd2050, 12'd3000, 12'd12);
    wait_idle();
  endtask

  // Sink holds off for a long stretch while the source keeps offering
  task automatic test_output_backpressure();
    int k;
    src_max_gap = 0;
    sink_hold   = HoldCycles;
    for (k = 0; k < 10; k++) begin
      send_tick($urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
    end
    wait_idle();
    src_max_gap = MaxGap;
  endtask

  // Reset, random or extreme settings per phase; slowly moving plant samples with some noise
  task automatic test_random_ticks();
    int phase, k, target, s_now, c_now;
    int cur_w, volt_w, spd_w;
    for (phase = 0; phase < 12; phase++) begin
      spd_w = $urandom_range(0, 4095);
      case (phase % 4)
        0: begin
          queue_all_regs(TargetRst, SNowRst, SPrevRst, SOutRst, CNowRst, CPrevRst, COutRst);
          spd_w = 11;
        end
        1: begin
          target = $urandom_range(0, 2000000000);
          s_now  = int'($urandom_range(0, 1 << 15)) - (1 << 14);
          c_now  = int'($urandom_range(0, 1 << 23)) - (1 << 22);
          queue_all_regs(target, s_now, -s_now + int'($urandom_range(0, 2048)) - 1024,
                         $urandom_range(58000, 66000), c_now,
                         -c_now + int'($urandom_range(0, 1 << 15)) - (1 << 14),
                         $urandom_range(58000, 66000));
          spd_w = (target / int'(RpmGain) > 4095) ? 4095 : target / int'(RpmGain);
        end
        2: queue_all_regs($urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom);
        default: queue_all_regs(pick_extreme(), pick_extreme(), pick_extreme(),
                                pick_extreme(), pick_extreme(), pick_extreme(),
                                pick_extreme());
      endcase
      apply_writes();
      src_max_gap  = (phase % 3 == 1) ? 0 : MaxGap;
      sink_max_gap = (phase % 4 == 2) ? 0 : MaxGap;
      cur_w  = walk(2078, 200);
      volt_w = $urandom_range(0, 4095);
      for (k = 0; k < 170; k++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_tick($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095));
        end else begin
          cur_w  = walk(cur_w, 8);
          volt_w = walk(volt_w, 4);
          spd_w  = walk(spd_w, 2);
          send_tick(cur_w, volt_w, spd_w);
        end
      end
    end
    wait_idle();
    src_max_gap  = MaxGap;
    sink_max_gap = MaxGap;
  endtask

  // Sequence of tests
  initial begin : stimulus
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    rst_ni        = 1'b0;
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_gain_extremes();
    test_unknown_register();
    test_output_backpressure();
    test_random_ticks();

    wait_idle();
    if (expected_ticks.size() != 0) begin
      report_mismatch("missing beats", expected_ticks.size(), 0);
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/cscpi_pkg.sv
rtl/core/cscpi_dp.sv
rtl/core/cscpi_ctrl.sv
rtl/core/cascaded_speed_current_pi.sv
sim/testbench.sv
